/* src/ssn_pkg.sv */
// Shared types, constants and register codes of the scale-space 3x3x3 non-maximum suppressor.
package ssn_pkg;

  // LINE_WIDTH must be a power of two; the line index is the low column bits.
  localparam int LINE_WIDTH = 1024;
  localparam int DET_BITS   = 32;
  localparam int LINE_AW    = $clog2(LINE_WIDTH);
  localparam int NUM_SCALES = 3;
  localparam int ENTRY_W    = 2 * NUM_SCALES * DET_BITS;

  typedef logic signed [DET_BITS-1:0] det_t;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_FRAME_COLS = 3'd1,
    REG_FRAME_ROWS = 3'd2,
    REG_SCAN_FIRST = 3'd3,
    REG_SCAN_COL_END = 3'd4,
    REG_SCAN_ROW_END = 3'd5,
    REG_COORD_OFFSET = 3'd6
  } cfg_reg_e;

  localparam logic signed [31:0] RST_THRESHOLD = 32'sd0;
  localparam logic [10:0] RST_FRAME_COLS = 11'd791;
  localparam logic [10:0] RST_FRAME_ROWS = 11'd591;
  localparam logic [9:0]  RST_SCAN_FIRST = 10'd8;
  localparam logic [10:0] RST_SCAN_COL_END = 11'd785;
  localparam logic [10:0] RST_SCAN_ROW_END = 11'd585;
  localparam logic [7:0]  RST_COORD_OFFSET = 8'd4;

  localparam logic [10:0] MAX_INDEX = 11'd1023;
  localparam logic [15:0] POINT_MAX = 16'hFFFF;

  typedef struct packed {
    logic signed [31:0] det_small;
    logic signed [31:0] det_mid;
    logic signed [31:0] det_large;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic [14:0] key_row;
    logic [14:0] key_col;
    logic [15:0] point_index;
  } out_item_t;

endpackage

/* src/ssn_stream_if.sv */
// Valid/ready stream interfaces for determinant items and key point items.
interface ssn_in_if;
  logic               valid;
  logic               ready;
  ssn_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssn_out_if;
  logic               valid;
  logic               ready;
  ssn_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/scale_space_nms_3x3x3_top.sv */
// Scale-space 3x3x3 non-maximum suppression top level: line memory, window, compare, output.
//
// One determinant item (three scales) is taken per clock while the output is not stalled; a key
// point item is loaded into the output register by the item in stage 1 that completes its 3x3x3
// neighbourhood. Throughput is set by the line memory: one read and one write of a 2-row entry
// per item, with the entry written by the previous item forwarded when the same column is read
// again (narrow frames, frame restart at column 0). The block holds one item in flight besides
// the output register, and a stall at the output stops the input. Line memory content is not
// cleared; the first two rows after reset read whatever it holds.
module scale_space_nms_3x3x3_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  ssn_in_if.sink           in_i,
  ssn_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i
);

  localparam int DB = ssn_pkg::DET_BITS;
  localparam int AW = ssn_pkg::LINE_AW;
  localparam int NS = ssn_pkg::NUM_SCALES;

  // configuration
  logic signed [31:0] thr_q;
  logic [10:0]        fcols_q;
  logic [10:0]        frows_q;
  logic [9:0]         sfirst_q;
  logic [10:0]        scol_end_q;
  logic [10:0]        srow_end_q;
  logic [7:0]         off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= ssn_pkg::RST_THRESHOLD;
      fcols_q    <= ssn_pkg::RST_FRAME_COLS;
      frows_q    <= ssn_pkg::RST_FRAME_ROWS;
      sfirst_q   <= ssn_pkg::RST_SCAN_FIRST;
      scol_end_q <= ssn_pkg::RST_SCAN_COL_END;
      srow_end_q <= ssn_pkg::RST_SCAN_ROW_END;
      off_q      <= ssn_pkg::RST_COORD_OFFSET;
    end else if (cfg_we_i) begin
      unique case (ssn_pkg::cfg_reg_e'(cfg_idx_i))
        ssn_pkg::REG_THRESHOLD:    thr_q      <= cfg_data_i;
        ssn_pkg::REG_FRAME_COLS:   fcols_q    <= cfg_data_i[10:0];
        ssn_pkg::REG_FRAME_ROWS:   frows_q    <= cfg_data_i[10:0];
        ssn_pkg::REG_SCAN_FIRST:   sfirst_q   <= cfg_data_i[9:0];
        ssn_pkg::REG_SCAN_COL_END: scol_end_q <= cfg_data_i[10:0];
        ssn_pkg::REG_SCAN_ROW_END: srow_end_q <= cfg_data_i[10:0];
        ssn_pkg::REG_COORD_OFFSET: off_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic out_v_q;
  logic s1_v_q;
  logic en;
  logic in_fire;
  logic s1_proc;

  assign en       = !out_v_q || out_o.ready;
  assign in_fire  = in_i.valid && en;
  assign s1_proc  = s1_v_q && en;
  assign in_i.ready = en;

  // stage 0: position counters and line read
  logic [9:0]  row_q, col_q;
  logic [9:0]  row_cur, col_cur;
  logic [10:0] col_nx, row_nx;
  logic        wrap_c, wrap_r;
  logic [AW-1:0] li;

  assign row_cur = in_i.data.frame_start ? 10'd0 : row_q;
  assign col_cur = in_i.data.frame_start ? 10'd0 : col_q;
  assign col_nx  = {1'b0, col_cur} + 11'd1;
  assign row_nx  = {1'b0, row_cur} + 11'd1;
  assign wrap_c  = (col_nx >= fcols_q) || (col_nx > ssn_pkg::MAX_INDEX);
  assign wrap_r  = (row_nx >= frows_q) || (row_nx > ssn_pkg::MAX_INDEX);
  assign li      = AW'(col_cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_fire) begin
      if (wrap_c) begin
        col_q <= '0;
        row_q <= wrap_r ? 10'd0 : row_nx[9:0];
      end else begin
        row_q <= row_cur;
        col_q <= col_nx[9:0];
      end
    end
  end

  // stage 1 registers
  logic [9:0]                s1_row_q, s1_col_q;
  logic [AW-1:0]             s1_li_q;
  logic                      s1_fs_q;
  ssn_pkg::det_t             s1_cur_q [NS];
  logic                      fwd_q;
  logic [ssn_pkg::ENTRY_W-1:0] rd_q, wdata_q, wdata, rows;
  logic [ssn_pkg::ENTRY_W-1:0] mem_q [ssn_pkg::LINE_WIDTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      if (en) s1_v_q <= in_fire;
      if (in_fire) fwd_q <= s1_proc && (s1_li_q == li);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_row_q    <= row_cur;
      s1_col_q    <= col_cur;
      s1_li_q     <= li;
      s1_fs_q     <= in_i.data.frame_start;
      s1_cur_q[0] <= ssn_pkg::det_t'(in_i.data.det_small);
      s1_cur_q[1] <= ssn_pkg::det_t'(in_i.data.det_mid);
      s1_cur_q[2] <= ssn_pkg::det_t'(in_i.data.det_large);
      rd_q        <= mem_q[li];
    end
    if (s1_proc) begin
      mem_q[s1_li_q] <= wdata;
      wdata_q        <= wdata;
    end
  end

  // stage 1: column assembly, compare, window shift
  ssn_pkg::det_t colv [NS][3];
  ssn_pkg::det_t win_q [NS][3][2];
  ssn_pkg::det_t centre, thr;
  logic          all_gt, in_scan, hit;
  logic [15:0]   pc_q, pc_eff;

  assign rows = fwd_q ? wdata_q : rd_q;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      colv[s][0] = rows[s*DB +: DB];
      colv[s][1] = rows[(NS+s)*DB +: DB];
      colv[s][2] = s1_cur_q[s];
      wdata[s*DB +: DB]      = colv[s][1];
      wdata[(NS+s)*DB +: DB] = colv[s][2];
    end
  end

  assign centre = win_q[1][1][0];
  assign thr    = ssn_pkg::det_t'(thr_q);

  always_comb begin
    all_gt = 1'b1;
    for (int s = 0; s < NS; s++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(centre > colv[s][j])) all_gt = 1'b0;
        if (!(centre > win_q[s][j][1])) all_gt = 1'b0;
        if (!(s == 1 && j == 1) && !(centre > win_q[s][j][0])) all_gt = 1'b0;
      end
    end
  end

  assign in_scan = (s1_row_q >= sfirst_q) && ({1'b0, s1_row_q} < srow_end_q) &&
                   (s1_col_q >= sfirst_q) && ({1'b0, s1_col_q} < scol_end_q);
  assign hit     = in_scan && (centre > thr) && all_gt;
  assign pc_eff  = s1_fs_q ? 16'd0 : pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      for (int s = 0; s < NS; s++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[s][j][0] <= '0;
          win_q[s][j][1] <= '0;
        end
      end
    end else if (s1_proc) begin
      pc_q <= (hit && pc_eff != ssn_pkg::POINT_MAX) ? pc_eff + 16'd1 : pc_eff;
      for (int s = 0; s < NS; s++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[s][j][1] <= win_q[s][j][0];
          win_q[s][j][0] <= colv[s][j];
        end
      end
    end
  end

  // output register
  ssn_pkg::out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= s1_v_q && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_proc && hit) begin
      out_data_q.key_row     <= 15'({1'b0, s1_row_q} + {3'b000, off_q});
      out_data_q.key_col     <= 15'({1'b0, s1_col_q} + {3'b000, off_q});
      out_data_q.point_index <= pc_eff;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_data_q;

  // checks
  a_out_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s1_v_q))
    else $error("output raised without an item in stage 1");

  a_fwd_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_fire) && fwd_q) |-> (s1_li_q == $past(s1_li_q)))
    else $error("forward flag set for a different line entry");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !en) |=> s1_v_q)
    else $error("pending item dropped during output stall");

endmodule
